### hdl/button_debounce_long_press_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the button debouncer
// Concurrent checks sampled on clk and disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_LONG_PRESS_ASSERT_SVH
`define BUTTON_DEBOUNCE_LONG_PRESS_ASSERT_SVH

// same-cycle implication
`define BDLP_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BDLP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/bdlp_pkg.sv
// ---------------------------------------------------------------------------
// bdlp_pkg
// Beat types, codes and reset values shared by the debouncer modules.
// ---------------------------------------------------------------------------
package bdlp_pkg;

	// item opcodes
	localparam logic OP_POLL  = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	// register indexes
	localparam logic REG_DEBOUNCE   = 1'b0;
	localparam logic REG_LONG_PRESS = 1'b1;

	localparam logic [31:0] DEBOUNCE_RESET   = 32'd20;
	localparam logic [31:0] LONG_PRESS_RESET = 32'd1000;

	typedef enum logic [1:0] {
		MODE_IDLE       = 2'd0,
		MODE_PRESS_DB   = 2'd1,
		MODE_PRESSED    = 2'd2,
		MODE_RELEASE_DB = 2'd3
	} mode_t;

	typedef struct packed {
		logic        op;
		logic [31:0] now_ms;
		logic        pin_level;
	} in_item_t;

	typedef struct packed {
		logic       event_pending;
		logic       event_long;
		logic [1:0] debounce_state;
	} out_item_t;

	typedef struct packed {
		logic [31:0] debounce_time;
		logic [31:0] long_press_time;
	} cfg_t;

endpackage

### hdl/button_debounce_long_press.sv
// ---------------------------------------------------------------------------
// button_debounce_long_press
// Push-button debouncer with long-press detection, one result per item.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries poll beats with a
//   millisecond timestamp and the raw active-low pin, or a clear beat that
//   drops the pending event flag. Every input beat yields exactly one
//   output beat (out_valid / out_stall / out_data) with the flags and the
//   debounce state after that item.
//   Path: an accepted beat lands in the input register, and its result
//   moves into the output register once the output beat is not held by
//   out_stall; out_valid is driven by the output register.
//   Throughput: one item per cycle unless out_stall holds the output;
//   the state machine and its single subtract-and-compare per timer sit
//   between both registers; the next item sees the new state without a bubble.
//   Stall: when the output beat is held by out_stall the input register
//   keeps its item and in_stall rises only if that register is occupied.
//   Reset: state idle, timestamps zero, flags clear, debounce_time 20 and
//   long_press_time 1000. The user must write timing registers via cfg_we
//   only while no items are in flight; the block does not enforce this.
// ---------------------------------------------------------------------------
module button_debounce_long_press (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [31:0]         cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  bdlp_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output bdlp_pkg::out_item_t out_data
);
	import bdlp_pkg::*;

	cfg_t      cfg;
	in_item_t  data_s1;
	logic      valid_s1;
	out_item_t data_s2;
	logic      valid_s2;
	out_item_t result;
	logic      hold;     // output beat waiting on the receiver
	logic      advance;  // s1 item moves into the output register

	bdlp_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign hold     = valid_s2 && out_stall;
	assign advance  = valid_s1 && !hold;
	assign in_stall = valid_s1 && hold;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_s1 <= in_data;
		end
	end

	// state machine commits exactly when its result is captured
	bdlp_fsm u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (data_s1),
		.cfg    (cfg),
		.result (result)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!hold) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			data_s2 <= result;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

`include "button_debounce_long_press_assert.svh"

	// an unblocked s1 item always lands in the output register
	`BDLP_ASSERT_NEXT(a_forward, advance, valid_s2, "s1 beat lost on advance")
	// a taken output beat with nothing behind it empties the register
	`BDLP_ASSERT_NEXT(a_drain, valid_s2 && !out_stall && !valid_s1, !valid_s2,
		"output beat repeated")
	// a clear beat always reports no pending event
	`BDLP_ASSERT_NEXT(a_clear, advance && data_s1.op == OP_CLEAR, !data_s2.event_pending,
		"clear beat left event pending")

endmodule

### hdl/bdlp_cfg_regs.sv
// ---------------------------------------------------------------------------
// bdlp_cfg_regs
// Timing registers, written through a plain write port.
// ---------------------------------------------------------------------------
module bdlp_cfg_regs (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [31:0]  cfg_data,
	output bdlp_pkg::cfg_t cfg
);
	import bdlp_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_time   <= DEBOUNCE_RESET;
			cfg_q.long_press_time <= LONG_PRESS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DEBOUNCE:   cfg_q.debounce_time   <= cfg_data;
				REG_LONG_PRESS: cfg_q.long_press_time <= cfg_data;
				default:        ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### hdl/bdlp_fsm.sv
// ---------------------------------------------------------------------------
// bdlp_fsm
// Debounce state machine with hold timing; updates once per stepped beat.
// ---------------------------------------------------------------------------
module bdlp_fsm (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  bdlp_pkg::in_item_t  item,
	input  bdlp_pkg::cfg_t      cfg,
	output bdlp_pkg::out_item_t result
);
	import bdlp_pkg::*;

	mode_t       mode_q, mode_d;
	logic [31:0] change_time_q, change_time_d;
	logic [31:0] press_time_q, press_time_d;
	logic        event_q, event_d;
	logic        long_q, long_d;

	logic [31:0] since_change;
	logic [31:0] held_for;
	logic        elapsed;
	logic        is_long;
	logic        down;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= MODE_IDLE;
			change_time_q <= '0;
			press_time_q  <= '0;
			event_q       <= 1'b0;
			long_q        <= 1'b0;
		end else if (step) begin
			mode_q        <= mode_d;
			change_time_q <= change_time_d;
			press_time_q  <= press_time_d;
			event_q       <= event_d;
			long_q        <= long_d;
		end
	end

	// wrapping elapsed times
	assign since_change = item.now_ms - change_time_q;
	assign held_for     = item.now_ms - press_time_q;
	assign elapsed      = since_change >= cfg.debounce_time;
	assign is_long      = held_for >= cfg.long_press_time;
	assign down         = !item.pin_level;

	always_comb begin
		mode_d        = mode_q;
		change_time_d = change_time_q;
		press_time_d  = press_time_q;
		event_d       = event_q;
		long_d        = long_q;
		if (item.op == OP_CLEAR) begin
			event_d = 1'b0;
		end else begin
			unique case (mode_q)
				MODE_IDLE: begin
					if (down) begin
						mode_d        = MODE_PRESS_DB;
						change_time_d = item.now_ms;
					end
				end
				MODE_PRESS_DB: begin
					if (elapsed) begin
						if (down) begin
							mode_d       = MODE_PRESSED;
							press_time_d = item.now_ms;
						end else begin
							mode_d = MODE_IDLE;
						end
					end
				end
				MODE_PRESSED: begin
					if (!down) begin
						mode_d        = MODE_RELEASE_DB;
						change_time_d = item.now_ms;
					end
				end
				MODE_RELEASE_DB: begin
					// bounce back to pressed keeps the original press time
					if (elapsed) begin
						if (!down) begin
							long_d  = is_long;
							event_d = 1'b1;
							mode_d  = MODE_IDLE;
						end else begin
							mode_d = MODE_PRESSED;
						end
					end
				end
				default: mode_d = MODE_IDLE;
			endcase
		end
	end

	assign result.event_pending  = event_d;
	assign result.event_long     = long_d;
	assign result.debounce_state = mode_d;

endmodule
